// ===== rtl/core/lprr_pkg.sv =====
// Shared field widths, operation codes, state encoding and constants of the record ring.
package lprr_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned CNT_W  = 10;

  // Every record starts with a two-byte length header, low byte first.
  localparam int unsigned HEADER_BYTES = 2;

  // The record counter stops accepting reservations at this value.
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR_HI,
    ST_FETCH,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/lprr_if.sv =====
// Valid/ready channel interfaces for the record ring requests and responses.
interface lprr_in_if import lprr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [LEN_W-1:0]  record_length;
  logic [BYTE_W-1:0] data_byte;
  logic [OFF_W-1:0]  read_offset;

  modport source (output valid, output op, output record_length, output data_byte,
                  output read_offset, input ready);
  modport sink   (input valid, input op, input record_length, input data_byte,
                  input read_offset, output ready);
endinterface

interface lprr_out_if import lprr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [LEN_W-1:0]  length_out;
  logic [OFF_W-1:0]  payload_offset;
  logic [BYTE_W-1:0] byte_out;
  logic [CNT_W-1:0]  record_count;

  modport source (output valid, output ok, output length_out, output payload_offset,
                  output byte_out, output record_count, input ready);
  modport sink   (input valid, input ok, input length_out, input payload_offset,
                  input byte_out, input record_count, output ready);
endinterface

// ===== rtl/core/lprr_store.sv =====
// Byte store of the record ring: one write port and two registered read ports.
module lprr_store import lprr_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [BYTE_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [BYTE_W-1:0]        rd_data_a_o,
  output logic [BYTE_W-1:0]        rd_data_b_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

// ===== rtl/core/length_prefixed_record_ring.sv =====
// Top level of the length-prefixed record ring: control, pointers and response register.
//
//   Channel  Dir  Contents
//   in_i     in   op, record_length, data_byte, read_offset
//   out_o    out  ok, length_out, payload_offset, byte_out, record_count
//
// One request is worked on at a time. A payload write or a refused request goes from
// idle straight to the done state; a reserve passes the high header byte state (two
// header byte writes on the single store write port), a dequeue or byte read the fetch
// state, which waits for the registered store read. The done state holds while the
// response register is occupied and out_o.ready stays low. After reset the store is
// swept to zero, one byte per cycle, and no request is taken meanwhile. A response waits
// in its register while out_o.ready is low, and the block stays in ST_DONE until it frees.
module length_prefixed_record_ring import lprr_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lprr_in_if.sink     in_i,
  lprr_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned PW = $clog2(STORE_BYTES + 1);
  localparam int unsigned XW = (PW >= 16) ? PW + 1 : 17;
  localparam logic [XW-1:0] STORE_X = XW'(STORE_BYTES);
  localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);

  state_e            state_q, state_d;
  logic [PW-1:0]     clr_q, clr_d;
  logic [PW-1:0]     wpos_q, wpos_d;
  logic [PW-1:0]     rpos_q, rpos_d;
  logic [PW-1:0]     wrap_q, wrap_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [LEN_W-1:0]  left_q, left_d;

  logic [PW-1:0]     hdr_addr_q, hdr_addr_d;
  logic [BYTE_W-1:0] hdr_hi_q, hdr_hi_d;
  logic [PW-1:0]     rbase_q, rbase_d;
  logic              fetch_deq_q, fetch_deq_d;
  logic              lo_ok_q, lo_ok_d;
  logic              hi_ok_q, hi_ok_d;
  logic              res_ok_q, res_ok_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [OFF_W-1:0]  res_poff_q, res_poff_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;

  logic              ov_q, ov_d;
  logic              o_ok_q;
  logic [LEN_W-1:0]  o_len_q;
  logic [OFF_W-1:0]  o_poff_q;
  logic [BYTE_W-1:0] o_byte_q;
  logic [CNT_W-1:0]  o_cnt_q;
  logic              o_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_ra;
  logic [AW-1:0]     mem_rb;
  logic [BYTE_W-1:0] mem_da;
  logic [BYTE_W-1:0] mem_db;

  op_e               op;
  logic              in_ready;
  logic              in_fire;

  logic [XW-1:0]     xw;
  logic [XW-1:0]     xr;
  logic [XW-1:0]     need;
  logic [XW-1:0]     to_end;
  logic              rsv_block;
  logic              rsv_ok;
  logic              rsv_wrap;
  logic [XW-1:0]     wbase;
  logic [PW-1:0]     rb;
  logic [BYTE_W-1:0] rd_lo;
  logic [BYTE_W-1:0] rd_hi;
  logic [XW-1:0]     poff;
  logic [XW-1:0]     len16;

  lprr_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (mem_we),
    .wr_addr_i   (mem_waddr),
    .wr_data_i   (mem_wdata),
    .rd_addr_a_i (mem_ra),
    .rd_addr_b_i (mem_rb),
    .rd_data_a_o (mem_da),
    .rd_data_b_o (mem_db)
  );

  assign op       = op_e'(in_i.op);
  assign in_ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Space check for a reservation against the current pointers.
  always_comb begin
    xw        = XW'(wpos_q);
    xr        = XW'(rpos_q);
    need      = XW'(in_i.record_length) + HDR_X;
    to_end    = STORE_X - xw;
    rsv_block = (left_q != '0) || (held_q >= COUNT_MAX) ||
                ((wpos_q == rpos_q) && (held_q != '0));
    if (xw >= xr) begin
      rsv_ok   = !rsv_block && ((to_end >= need) || (xr >= need));
      rsv_wrap = (to_end < need);
    end else begin
      rsv_ok   = !rsv_block && ((xr - xw) >= need);
      rsv_wrap = 1'b0;
    end
    wbase = rsv_wrap ? '0 : xw;
  end

  // Dequeue restarts at the front of the store when it reaches the soft end.
  assign rb = (rpos_q == wrap_q) ? '0 : rpos_q;

  // Header bytes of a dequeued record, zero where the address lies beyond the store.
  assign rd_lo = lo_ok_q ? mem_da : '0;
  assign rd_hi = hi_ok_q ? mem_db : '0;
  assign len16 = XW'({rd_hi, rd_lo});
  assign poff  = XW'(rbase_q) + HDR_X;

  // Next state, pointer updates and store accesses.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    wrap_d      = wrap_q;
    held_d      = held_q;
    left_d      = left_q;
    hdr_addr_d  = hdr_addr_q;
    hdr_hi_d    = hdr_hi_q;
    rbase_d     = rbase_q;
    fetch_deq_d = fetch_deq_q;
    lo_ok_d     = lo_ok_q;
    hi_ok_d     = hi_ok_q;
    res_ok_d    = res_ok_q;
    res_len_d   = res_len_q;
    res_poff_d  = res_poff_q;
    res_byte_d  = res_byte_q;
    o_load      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(wpos_q);
    mem_wdata   = in_i.data_byte;
    mem_ra      = AW'(rb);
    mem_rb      = AW'(XW'(rb) + XW'(1));

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(clr_q);
        mem_wdata = '0;
        clr_d     = clr_q + PW'(1);
        if (clr_q == PW'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          res_ok_d   = 1'b0;
          res_len_d  = '0;
          res_poff_d = '0;
          res_byte_d = '0;
          state_d    = ST_DONE;
          unique case (op)
            OP_RESERVE: begin
              if (rsv_ok) begin
                held_d = held_q + CNT_W'(1);
                if (rsv_wrap) begin
                  wrap_d = wpos_q;
                end
                mem_we     = (wbase < STORE_X);
                mem_waddr  = AW'(wbase);
                mem_wdata  = in_i.record_length[BYTE_W-1:0];
                hdr_addr_d = PW'(wbase + XW'(1));
                hdr_hi_d   = BYTE_W'(in_i.record_length >> BYTE_W);
                wpos_d     = PW'(wbase + HDR_X);
                left_d     = in_i.record_length;
                res_ok_d   = 1'b1;
                state_d    = ST_HDR_HI;
              end
            end
            OP_WRITE: begin
              if (left_q != '0) begin
                mem_we    = (xw < STORE_X);
                mem_waddr = AW'(wpos_q);
                mem_wdata = in_i.data_byte;
                wpos_d    = wpos_q + PW'(1);
                left_d    = left_q - LEN_W'(1);
                res_ok_d  = 1'b1;
              end
            end
            OP_DEQUEUE: begin
              if (held_q != '0) begin
                held_d = held_q - CNT_W'(1);
                if (rpos_q == wrap_q) begin
                  wrap_d = PW'(STORE_BYTES);
                end
                lo_ok_d     = (XW'(rb) < STORE_X);
                hi_ok_d     = ((XW'(rb) + XW'(1)) < STORE_X);
                rbase_d     = rb;
                fetch_deq_d = 1'b1;
                res_ok_d    = 1'b1;
                state_d     = ST_FETCH;
              end
            end
            OP_READ: begin
              if (XW'(in_i.read_offset) < STORE_X) begin
                mem_ra      = AW'(in_i.read_offset);
                lo_ok_d     = 1'b1;
                hi_ok_d     = 1'b0;
                fetch_deq_d = 1'b0;
                res_ok_d    = 1'b1;
                state_d     = ST_FETCH;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_HDR_HI: begin
        mem_we    = (XW'(hdr_addr_q) < STORE_X);
        mem_waddr = AW'(hdr_addr_q);
        mem_wdata = hdr_hi_q;
        state_d   = ST_DONE;
      end

      ST_FETCH: begin
        if (fetch_deq_q) begin
          res_len_d  = len16[LEN_W-1:0];
          res_poff_d = poff[OFF_W-1:0];
          rpos_d     = PW'(poff + len16);
        end else begin
          res_byte_d = rd_lo;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          o_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response register valid flag.
  always_comb begin
    ov_d = ov_q;
    if (o_load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wpos_q  <= '0;
      rpos_q  <= '0;
      wrap_q  <= PW'(STORE_BYTES);
      held_q  <= '0;
      left_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      wrap_q  <= wrap_d;
      held_q  <= held_d;
      left_q  <= left_d;
      ov_q    <= ov_d;
    end
  end

  // Working and response payload registers.
  always_ff @(posedge clk_i) begin
    hdr_addr_q  <= hdr_addr_d;
    hdr_hi_q    <= hdr_hi_d;
    rbase_q     <= rbase_d;
    fetch_deq_q <= fetch_deq_d;
    lo_ok_q     <= lo_ok_d;
    hi_ok_q     <= hi_ok_d;
    res_ok_q    <= res_ok_d;
    res_len_q   <= res_len_d;
    res_poff_q  <= res_poff_d;
    res_byte_q  <= res_byte_d;
    if (o_load) begin
      o_ok_q   <= res_ok_q;
      o_len_q  <= res_len_q;
      o_poff_q <= res_poff_q;
      o_byte_q <= res_byte_q;
      o_cnt_q  <= held_q;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.ok             = o_ok_q;
  assign out_o.length_out     = o_len_q;
  assign out_o.payload_offset = o_poff_q;
  assign out_o.byte_out       = o_byte_q;
  assign out_o.record_count   = o_cnt_q;

  // The write position never runs past the end of the store.
  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(wpos_q) <= STORE_X)
    else $error("write position beyond store end");

  // The soft end mark never lies beyond the store.
  a_wrap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(wrap_q) <= STORE_X)
    else $error("wrap mark beyond store end");

  // An accepted payload byte uses up exactly one byte of the open record.
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_WRITE) && (left_q != '0)) |=>
      (left_q == ($past(left_q) - LEN_W'(1))))
    else $error("payload count not decremented");

  // A granted reservation opens the record and writes the high header byte next.
  a_reserve_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_RESERVE) && rsv_ok) |=>
      ((state_q == ST_HDR_HI) && (left_q == $past(in_i.record_length))))
    else $error("reservation did not open the record");

endmodule
